### rtl/core/tpg_pkg.sv
// ----------------------------------------------------------------------------
// tpg_pkg: shared types and constants for the term pattern grounding matcher
// Word layouts of the term-pair input and the match result, plus the
// per-term update bundle passed from the evaluator to the top level.
// ----------------------------------------------------------------------------
package tpg_pkg;

    localparam int ID_BITS      = 16;
    localparam int MAX_VARS_DEF = 16;

    typedef struct packed {
        logic               first_term;
        logic [ID_BITS-1:0] pattern_pred_id;
        logic [ID_BITS-1:0] ground_pred_id;
        logic               term_is_variable;
        logic [ID_BITS-1:0] pattern_term_id;
        logic [ID_BITS-1:0] ground_term_id;
        logic               last_term;
    } tpg_in_t;

    typedef struct packed {
        logic can_ground;
        logic bad_variable;
    } tpg_out_t;

    // Outcome of checking one term pair
    typedef struct packed {
        logic bind_we;   // first sighting of a legal variable: record binding
        logic mismatch;  // predicate, constant or binding disagreement
        logic bad_var;   // variable number zero or out of range
    } tpg_upd_t;

endpackage

### rtl/core/tpg_bind_store.sv
// ----------------------------------------------------------------------------
// tpg_bind_store: variable binding storage
// Binding values in a memory with a registered read issued when a word is
// accepted; valid bits in flops, cleared at the start of each predicate.
// A write landing on the same edge as the read is forwarded.
// ----------------------------------------------------------------------------
module tpg_bind_store
    import tpg_pkg::*;
#(
    parameter int MAX_VARS = MAX_VARS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        rd_en,
    input  logic [$clog2(MAX_VARS)-1:0] rd_addr,
    output logic [ID_BITS-1:0]          rd_data,
    input  logic [$clog2(MAX_VARS)-1:0] cur_addr,
    output logic                        cur_valid,
    input  logic                        clr,
    input  logic                        wr_en,
    input  logic [ID_BITS-1:0]          wr_data
);

    logic [ID_BITS-1:0]  mem [MAX_VARS];
    logic [ID_BITS-1:0]  rd_data_reg;
    logic [ID_BITS-1:0]  fwd_data_reg;
    logic                fwd_hit_reg;
    logic [MAX_VARS-1:0] valid_reg;
    logic [MAX_VARS-1:0] valid_next;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[cur_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // the memory read misses a write on the same edge; remember it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_hit_reg <= wr_en && (cur_addr == rd_addr);
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

    always_comb begin
        valid_next = clr ? '0 : valid_reg;
        if (wr_en) begin
            valid_next[cur_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign cur_valid = valid_reg[cur_addr];

endmodule

### rtl/core/tpg_term_eval.sv
// ----------------------------------------------------------------------------
// tpg_term_eval: term pair checker
// Compares predicate ids, constants and existing bindings for one term pair
// and flags out-of-range variable numbers.
// ----------------------------------------------------------------------------
module tpg_term_eval
    import tpg_pkg::*;
#(
    parameter int MAX_VARS = MAX_VARS_DEF
) (
    input  tpg_in_t            item,
    input  logic               bound_valid,
    input  logic [ID_BITS-1:0] bound_value,
    output tpg_upd_t           upd
);

    localparam int CMP_BITS = ID_BITS + $clog2(MAX_VARS) + 1;

    logic out_of_range;
    logic bound_eff;
    logic pred_diff;
    logic const_diff;
    logic bind_diff;

    assign out_of_range = (item.pattern_term_id == '0) ||
                          (CMP_BITS'(item.pattern_term_id) >= CMP_BITS'(MAX_VARS));

    // a first-term word sees all bindings as cleared
    assign bound_eff  = bound_valid && !item.first_term;
    assign pred_diff  = item.pattern_pred_id != item.ground_pred_id;
    assign const_diff = !item.term_is_variable &&
                        (item.pattern_term_id != item.ground_term_id);
    assign bind_diff  = item.term_is_variable && !out_of_range && bound_eff &&
                        (bound_value != item.ground_term_id);

    assign upd.bind_we  = item.term_is_variable && !out_of_range && !bound_eff;
    assign upd.mismatch = pred_diff || const_diff || bind_diff;
    assign upd.bad_var  = item.term_is_variable && out_of_range;

endmodule

### rtl/core/term_pattern_grounding_matcher_unit.sv
// ----------------------------------------------------------------------------
// term_pattern_grounding_matcher_unit: pattern vs ground predicate matcher
// A last-term word is accepted into the input register; its result word then
// reaches m_data through the result register once that slot is free.
// Throughput: one term-pair word per cycle, set by the single binding memory
// read per word and one write per word; stalls only when m_ready holds off.
// Reset (aresetn low, synchronous) empties both registers and clears the
// binding valid bits and the mismatch/error flags; binding values are kept.
// ----------------------------------------------------------------------------
module term_pattern_grounding_matcher_unit
    import tpg_pkg::*;
#(
    parameter int MAX_VARS = MAX_VARS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  tpg_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output tpg_out_t m_data
);

    localparam int VAR_BITS = $clog2(MAX_VARS);

    logic                in_vld_reg;
    tpg_in_t             in_reg;
    logic                out_vld_reg;
    tpg_out_t            out_reg;
    logic                mis_reg;
    logic                err_reg;
    logic                mis_next;
    logic                err_next;
    logic                advance;
    logic                accept;
    logic [VAR_BITS-1:0] cur_addr;
    logic                bound_valid;
    logic [ID_BITS-1:0]  bound_value;
    tpg_upd_t            upd;

    // a last-term word moves only when the result slot frees up
    assign advance  = in_vld_reg && (!in_reg.last_term || !out_vld_reg || m_ready);
    assign s_ready  = !in_vld_reg || advance;
    assign accept   = s_valid && s_ready;
    assign cur_addr = VAR_BITS'(in_reg.pattern_term_id);

    tpg_bind_store #(
        .MAX_VARS (MAX_VARS)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (accept),
        .rd_addr   (VAR_BITS'(s_data.pattern_term_id)),
        .rd_data   (bound_value),
        .cur_addr  (cur_addr),
        .cur_valid (bound_valid),
        .clr       (advance && in_reg.first_term),
        .wr_en     (advance && upd.bind_we),
        .wr_data   (in_reg.ground_term_id)
    );

    tpg_term_eval #(
        .MAX_VARS (MAX_VARS)
    ) u_eval (
        .item        (in_reg),
        .bound_valid (bound_valid),
        .bound_value (bound_value),
        .upd         (upd)
    );

    assign mis_next = (mis_reg && !in_reg.first_term) || upd.mismatch;
    assign err_next = (err_reg && !in_reg.first_term) || upd.bad_var;

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            mis_reg    <= 1'b0;
            err_reg    <= 1'b0;
        end else begin
            if (accept) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end
            if (advance) begin
                mis_reg <= mis_next;
                err_reg <= err_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance && in_reg.last_term) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_reg.last_term) begin
            out_reg.can_ground   <= !mis_next && !err_next;
            out_reg.bad_variable <= err_next;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    // a held word that is not last never stalls
    a_mid_term_flows: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && !in_reg.last_term) |-> advance)
        else $error("non-last term word stalled");

    // every last-term word that moves produces a result word
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_reg.last_term) |=> m_valid)
        else $error("last term did not produce a result");

    // a match is never reported together with a bad variable
    a_match_excludes_err: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.can_ground) |-> !m_data.bad_variable)
        else $error("match reported with bad variable");

    // input side always free when the input register is empty
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_vld_reg |-> s_ready)
        else $error("input not ready while empty");

endmodule

### dv/term_pattern_grounding_matcher_unit_tb.sv
// ----------------------------------------------------------------------------
// term_pattern_grounding_matcher_unit_tb: self-checking bench for the matcher
// Streams directed and random predicate term pairs through the block, tracks
// variable bindings and flags in a scoreboard model, and checks each match
// result word field by field under several sender/receiver idle patterns.
// ----------------------------------------------------------------------------
module term_pattern_grounding_matcher_unit_tb
    import tpg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_VARS      = MAX_VARS_DEF;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_WORDS  = 195;   // per idle phase
    localparam int DRAIN_LIMIT   = 5000;

    typedef logic [ID_BITS-1:0] id_t;

    // ------------------------------------------------------------------------
    // Binding tracker and expected result store
    // ------------------------------------------------------------------------
    class match_scoreboard;
        id_t      bound_val [NUM_VARS];
        bit       bound_ok  [NUM_VARS];
        bit       mismatch;
        bit       bad_var;
        tpg_out_t expected_q[$];
        int       errors;

        function new();
            foreach (bound_ok[i]) begin
                bound_ok[i]  = 1'b0;
                bound_val[i] = '0;
            end
            mismatch = 1'b0;
            bad_var  = 1'b0;
            errors   = 0;
        endfunction

        function void note_input(tpg_in_t w);
            tpg_out_t r;
            int       v;
            if (w.first_term) begin
                foreach (bound_ok[i]) bound_ok[i] = 1'b0;
                mismatch = 1'b0;
                bad_var  = 1'b0;
            end
            if (w.pattern_pred_id != w.ground_pred_id)
                mismatch = 1'b1;
            if (!w.term_is_variable) begin
                if (w.pattern_term_id != w.ground_term_id)
                    mismatch = 1'b1;
            end else if (w.pattern_term_id == '0 || w.pattern_term_id >= NUM_VARS) begin
                bad_var = 1'b1;
            end else begin
                v = int'(w.pattern_term_id);
                if (!bound_ok[v]) begin
                    bound_ok[v]  = 1'b1;
                    bound_val[v] = w.ground_term_id;
                end else if (bound_val[v] != w.ground_term_id) begin
                    mismatch = 1'b1;
                end
            end
            if (w.last_term) begin
                r.can_ground   = !mismatch && !bad_var;
                r.bad_variable = bad_var;
                expected_q.push_back(r);
            end
        endfunction

        function void check_result(tpg_out_t got);
            tpg_out_t exp_r;
            if (expected_q.size() == 0) begin
                $error("result word with no expectation pending: %b", got);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.can_ground !== exp_r.can_ground) begin
                $error("can_ground: expected %0b, got %0b", exp_r.can_ground, got.can_ground);
                errors++;
            end
            if (got.bad_variable !== exp_r.bad_variable) begin
                $error("bad_variable: expected %0b, got %0b",
                       exp_r.bad_variable, got.bad_variable);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void flag_leftover();
            if (expected_q.size() != 0) begin
                $error("%0d result words never arrived", expected_q.size());
                errors++;
            end
        endfunction
    endclass

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    tpg_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    tpg_out_t m_data;

    match_scoreboard sb = new();

    int gap_pct   = 0;
    int stall_pct = 0;
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;
    int hold_cnt  = 0;
    int words_sent = 0;

    term_pattern_grounding_matcher_unit #(
        .MAX_VARS (NUM_VARS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("FAIL term_pattern_grounding_matcher_unit");
        $finish;
    end

    // Receiver: checks accepted result words, random stalls, one long hold
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_result(m_data);
            if (hold_req && !hold_done) begin
                m_ready <= 1'b0;
                hold_cnt++;
                if (hold_cnt >= HOLD_CYCLES)
                    hold_done = 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic tpg_in_t mk(bit first, id_t pp, id_t gp, bit isv, id_t pt, id_t gt,
                                   bit last);
        tpg_in_t w;
        w.first_term       = first;
        w.pattern_pred_id  = pp;
        w.ground_pred_id   = gp;
        w.term_is_variable = isv;
        w.pattern_term_id  = pt;
        w.ground_term_id   = gt;
        w.last_term        = last;
        return w;
    endfunction

    // Called right after an edge; returns at the edge where the word is taken
    task automatic send_word(input tpg_in_t w);
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(w);
        words_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // One well-formed predicate with random content, or a little noise
    task automatic send_predicate();
        int      n;
        int      v;
        id_t     pid;
        id_t     g;
        tpg_in_t w;
        id_t     seen_val [NUM_VARS];
        bit      seen     [NUM_VARS];
        foreach (seen[i]) seen[i] = 1'b0;
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                w = mk(1'($urandom_range(1)), id_t'($urandom), id_t'($urandom),
                       1'($urandom_range(1)), id_t'($urandom), id_t'($urandom),
                       1'($urandom_range(1)));
                send_word(w);
            end
            return;
        end
        n   = $urandom_range(1, 8);
        pid = id_t'($urandom);
        for (int i = 0; i < n; i++) begin
            w = mk(i == 0, pid, pid, 1'($urandom_range(1)), '0, '0, i == n - 1);
            if (i == 0 && $urandom_range(29) == 0)
                w.first_term = 1'b0;    // missing first mark
            if ($urandom_range(19) == 0)
                w.ground_pred_id = id_t'($urandom);
            if (w.term_is_variable) begin
                if ($urandom_range(19) == 0) begin
                    w.pattern_term_id = ($urandom_range(2) == 0) ? id_t'(0)
                                        : id_t'($urandom_range(NUM_VARS, 16'hFFFF));
                    w.ground_term_id  = id_t'($urandom);
                end else begin
                    v = $urandom_range(1, $urandom_range(1) ? 4 : NUM_VARS - 1);
                    w.pattern_term_id = id_t'(v);
                    g = id_t'($urandom);
                    if (seen[v] && $urandom_range(9) < 8)
                        g = seen_val[v];
                    if (!seen[v]) begin
                        seen[v]     = 1'b1;
                        seen_val[v] = g;
                    end
                    w.ground_term_id = g;
                end
            end else begin
                w.pattern_term_id = id_t'($urandom);
                w.ground_term_id  = w.pattern_term_id;
                if ($urandom_range(9) == 0)
                    w.ground_term_id = w.pattern_term_id ^ id_t'($urandom_range(1, 16'hFFFF));
            end
            send_word(w);
        end
    endtask

    task automatic random_phase(input int gp, input int sp);
        int target;
        gap_pct   = gp;
        stall_pct = sp;
        target    = words_sent + RANDOM_WORDS;
        while (words_sent < target)
            send_predicate();
        drain();
    endtask

    initial begin
        int guard;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, each term kind, bad variables, missing marks
        send_word(mk(1, 16'h0000, 16'h0000, 0, 16'h0000, 16'h0000, 1));
        send_word(mk(1, 16'hFFFF, 16'hFFFF, 0, 16'hFFFF, 16'hFFFF, 1));
        send_word(mk(1, 16'h1234, 16'h1235, 0, 16'h0005, 16'h0005, 1));
        send_word(mk(1, 16'h0007, 16'h0007, 0, 16'hFFFF, 16'h0000, 1));
        send_word(mk(1, 16'h0009, 16'h0009, 1, 16'h0001, 16'hAAAA, 0));
        send_word(mk(0, 16'h0009, 16'h0009, 1, 16'h000F, 16'h5555, 0));
        send_word(mk(0, 16'h0009, 16'h0009, 1, 16'h0001, 16'hAAAA, 1));
        send_word(mk(1, 16'h0009, 16'h0009, 1, 16'h0003, 16'h0100, 0));
        send_word(mk(0, 16'h0009, 16'h0009, 1, 16'h0003, 16'h0101, 1));
        send_word(mk(1, 16'h0002, 16'h0002, 1, 16'h0000, 16'h0000, 1));
        send_word(mk(1, 16'h0002, 16'h0002, 1, 16'h0010, 16'h0000, 1));
        send_word(mk(1, 16'h0002, 16'h0002, 1, 16'hFFFF, 16'hFFFF, 1));
        send_word(mk(1, 16'h0003, 16'h0003, 1, 16'h000F, 16'hFFFF, 1));
        // no first mark: keeps the binding of var 15 from the word above
        send_word(mk(0, 16'h0003, 16'h0003, 1, 16'h000F, 16'h0001, 1));
        send_word(mk(0, 16'h0003, 16'h0003, 0, 16'h0004, 16'h0004, 1));
        send_word(mk(1, 16'h0003, 16'h0003, 1, 16'h000F, 16'h0001, 1));
        // first mark in mid-predicate restarts it
        send_word(mk(1, 16'h0004, 16'h0004, 0, 16'h0001, 16'h0002, 0));
        send_word(mk(1, 16'h0004, 16'h0004, 0, 16'h0002, 16'h0002, 0));
        send_word(mk(0, 16'h0004, 16'h0004, 1, 16'h0002, 16'h8001, 1));
        send_word(mk(1, 16'h8000, 16'h8000, 1, 16'h0000, 16'h1234, 0));
        send_word(mk(1, 16'h8000, 16'h8000, 1, 16'h0002, 16'h1234, 0));
        send_word(mk(0, 16'h8000, 16'h8000, 1, 16'h0002, 16'h1234, 1));
        drain();

        random_phase(0, 0);
        random_phase(66, 0);
        random_phase(0, 66);
        random_phase(21, 21);

        // long receiver hold while the sender keeps pushing
        hold_req = 1'b1;
        random_phase(0, 0);

        s_valid <= 1'b0;
        guard = 0;
        while (sb.pending() > 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (5) @(posedge aclk);
        sb.flag_leftover();
        if (sb.errors == 0)
            $display("PASS term_pattern_grounding_matcher_unit");
        else
            $display("FAIL term_pattern_grounding_matcher_unit");
        $finish;
    end

endmodule
